// ===== design/ifs_pkg.sv =====
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared types and codes of the instruction format splitter: template word
// selects, field kinds and the control bundles between core and matcher.
// ----------------------------------------------------------------------------
package ifs_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 6;

    // template word select codes
    typedef enum logic [2:0] {
        SEL_LENGTH = 3'd0,
        SEL_ONES   = 3'd1,
        SEL_ZEROS  = 3'd2,
        SEL_OPCODE = 3'd3,
        SEL_STARTS = 3'd4
    } word_sel_t;

    // field kind codes
    localparam logic KIND_OPCODE = 1'b0;
    localparam logic KIND_ARG    = 1'b1;

    // one template table write
    typedef struct packed {
        logic              en;
        logic [3:0]        index;
        word_sel_t         sel;
        logic [WORD_W-1:0] value;
    } wr_t;

    // accumulator view seen by the matcher
    typedef struct packed {
        logic              push;
        logic              data_bit;
        logic [CNT_W-1:0]  count;
        logic [WORD_W-1:0] pending;
        logic              clear;
    } acc_t;

    // mask words of one template
    typedef struct packed {
        logic [WORD_W-1:0] ones;
        logic [WORD_W-1:0] zeros;
        logic [WORD_W-1:0] opcode;
        logic [WORD_W-1:0] starts;
    } entry_t;

endpackage

// ===== design/ifs_matcher.sv =====
// ----------------------------------------------------------------------------
// ifs_matcher
// Template table with one consistency lane per entry. Each arriving stream
// bit is checked against one mask position of every entry; a hit is the
// lowest entry that is still consistent and whose length equals the new count.
// ----------------------------------------------------------------------------
module ifs_matcher #(
    parameter int TEMPLATES = 16,
    parameter int IDX_W     = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifs_pkg::wr_t         wr,
    input  ifs_pkg::acc_t        acc,
    output logic                 hit,
    output logic [IDX_W-1:0]     hit_index,
    input  logic [IDX_W-1:0]     rd_index,
    output ifs_pkg::entry_t      rd_entry
);

    logic [ifs_pkg::CNT_W-1:0]  len_reg    [TEMPLATES];
    logic [ifs_pkg::WORD_W-1:0] ones_reg   [TEMPLATES];
    logic [ifs_pkg::WORD_W-1:0] zeros_reg  [TEMPLATES];
    logic [ifs_pkg::WORD_W-1:0] opcode_reg [TEMPLATES];
    logic [ifs_pkg::WORD_W-1:0] starts_reg [TEMPLATES];
    logic [TEMPLATES-1:0]       ok_ones_reg;
    logic [TEMPLATES-1:0]       ok_zeros_reg;
    logic [TEMPLATES-1:0]       ok_ones_next;
    logic [TEMPLATES-1:0]       ok_zeros_next;
    logic [TEMPLATES-1:0]       lane_hit;
    logic [ifs_pkg::WORD_W-1:0] low_mask;
    logic [ifs_pkg::CNT_W-1:0]  count_inc;
    logic [4:0]                 pos;
    logic                       wr_hit;
    logic [IDX_W-1:0]           widx;
    logic                       ones_fit;
    logic                       zeros_fit;

    assign pos       = acc.count[4:0];
    assign count_inc = acc.count + ifs_pkg::CNT_W'(1);
    assign wr_hit    = wr.en && (32'(wr.index) < TEMPLATES);
    assign widx      = IDX_W'(wr.index);

    // positions already in the accumulator
    always_comb
    begin
        for (int i = 0; i < ifs_pkg::WORD_W; i++)
        begin
            low_mask[i] = (ifs_pkg::CNT_W'(i) < acc.count);
        end
    end

    // a rewritten mask is checked against the bits gathered so far
    assign ones_fit  = ((~acc.pending & wr.value & low_mask) == '0);
    assign zeros_fit = ((acc.pending & wr.value & low_mask) == '0);

    // per-entry check of the incoming bit
    always_comb
    begin
        for (int t = 0; t < TEMPLATES; t++)
        begin
            ok_ones_next[t]  = ok_ones_reg[t] & ~(ones_reg[t][pos] & ~acc.data_bit);
            ok_zeros_next[t] = ok_zeros_reg[t] & ~(zeros_reg[t][pos] & acc.data_bit);
            lane_hit[t]      = ok_ones_next[t] & ok_zeros_next[t]
                               & (len_reg[t] == count_inc);
        end
    end

    // lowest matching entry wins
    always_comb
    begin
        hit_index = '0;
        for (int t = TEMPLATES - 1; t >= 0; t--)
        begin
            if (lane_hit[t])
            begin
                hit_index = IDX_W'(t);
            end
        end
    end

    assign hit = acc.push && (lane_hit != '0);

    // table storage and lane flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TEMPLATES; t++)
            begin
                len_reg[t]    <= '0;
                ones_reg[t]   <= '0;
                zeros_reg[t]  <= '0;
                opcode_reg[t] <= '0;
                starts_reg[t] <= '0;
            end
            ok_ones_reg  <= '1;
            ok_zeros_reg <= '1;
        end
        else
        begin
            if (acc.clear)
            begin
                ok_ones_reg  <= '1;
                ok_zeros_reg <= '1;
            end
            else if (acc.push)
            begin
                ok_ones_reg  <= ok_ones_next;
                ok_zeros_reg <= ok_zeros_next;
            end
            if (wr_hit)
            begin
                case (wr.sel)
                    ifs_pkg::SEL_LENGTH:
                    begin
                        len_reg[widx] <= wr.value[ifs_pkg::CNT_W-1:0];
                    end
                    ifs_pkg::SEL_ONES:
                    begin
                        ones_reg[widx]    <= wr.value;
                        ok_ones_reg[widx] <= ones_fit;
                    end
                    ifs_pkg::SEL_ZEROS:
                    begin
                        zeros_reg[widx]    <= wr.value;
                        ok_zeros_reg[widx] <= zeros_fit;
                    end
                    ifs_pkg::SEL_OPCODE:
                    begin
                        opcode_reg[widx] <= wr.value;
                    end
                    ifs_pkg::SEL_STARTS:
                    begin
                        starts_reg[widx] <= wr.value;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // read port for the field gathering passes
    assign rd_entry.ones   = ones_reg[rd_index];
    assign rd_entry.zeros  = zeros_reg[rd_index];
    assign rd_entry.opcode = opcode_reg[rd_index];
    assign rd_entry.starts = starts_reg[rd_index];

endmodule

// ===== design/instruction_format_splitter_core.sv =====
// ----------------------------------------------------------------------------
// instruction_format_splitter_core
// Splits a serial bit stream into instructions by template match and emits
// the opcode field followed by each argument field.
// ----------------------------------------------------------------------------
// A data word (mode 0) or a template write (mode 1) is taken only while no
// instruction is being split. When a data bit completes an instruction, the
// core stops taking words while it gathers fields bit-serially from shift
// registers: a load state and a scan over the instruction's bits collect the
// opcode, an emit state puts it out, and if the format has arguments a second
// load state and scan walk the arguments, putting out each one closed by a
// start mark, and a final emit state puts out the last one. Output stalls
// lengthen the hold-off. Matching itself is done as bits arrive, one mask
// position of every template per cycle in which a data bit is taken. Data
// bits beyond the accumulator limit are dropped.
// ----------------------------------------------------------------------------
module instruction_format_splitter_core #(
    parameter int MAX_BITS  = 32,
    parameter int TEMPLATES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic        data_bit,
    input  logic [3:0]  entry_index,
    input  logic [2:0]  word_select,
    input  logic [31:0] word_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        field_kind,
    output logic [31:0] field_value,
    output logic [5:0]  field_width,
    output logic [3:0]  format_number,
    output logic        last
);

    localparam int LEN_CAP = (MAX_BITS < 32) ? MAX_BITS : 32;
    localparam int IDX_W   = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_OP,
        S_SCAN_OP,
        S_EMIT_OP,
        S_LOAD_ARG,
        S_SCAN_ARG,
        S_EMIT_LAST
    } state_t;

    state_t                     state_reg;
    logic [ifs_pkg::WORD_W-1:0] pending_reg;
    logic [ifs_pkg::WORD_W-1:0] pending_next;
    logic [ifs_pkg::CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]           fmt_reg;
    logic [ifs_pkg::WORD_W-1:0] bits_sr_reg;
    logic [ifs_pkg::WORD_W-1:0] ones_sr_reg;
    logic [ifs_pkg::WORD_W-1:0] zeros_sr_reg;
    logic [ifs_pkg::WORD_W-1:0] op_sr_reg;
    logic [ifs_pkg::WORD_W-1:0] st_sr_reg;
    logic [ifs_pkg::CNT_W-1:0]  pos_reg;
    logic [ifs_pkg::WORD_W-1:0] op_val_reg;
    logic [ifs_pkg::CNT_W-1:0]  op_w_reg;
    logic [ifs_pkg::WORD_W-1:0] arg_val_reg;
    logic [ifs_pkg::CNT_W-1:0]  arg_w_reg;
    logic                       has_arg_reg;
    logic                       open_reg;
    logic                       out_valid_reg;
    logic                       out_kind_reg;
    logic [ifs_pkg::WORD_W-1:0] out_value_reg;
    logic [ifs_pkg::CNT_W-1:0]  out_width_reg;
    logic [3:0]                 out_fmt_reg;
    logic                       out_last_reg;

    ifs_pkg::wr_t               wr;
    ifs_pkg::acc_t              acc;
    ifs_pkg::entry_t            rd_entry;
    logic                       hit;
    logic [IDX_W-1:0]           hit_index;

    logic                       accept;
    logic                       slot_free;
    logic                       finish;
    logic                       cur_bit;
    logic                       is_arg;
    logic                       scan_end;
    logic                       out_load;

    // handshake
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // accumulator update
    assign pending_next = pending_reg
                          | (ifs_pkg::WORD_W'(data_bit) << count_reg[4:0]);

    // bundles to the matcher
    assign wr.en    = accept && mode;
    assign wr.index = entry_index;
    assign wr.sel   = ifs_pkg::word_sel_t'(word_select);
    assign wr.value = word_value;

    assign acc.push     = accept && !mode && (count_reg < ifs_pkg::CNT_W'(LEN_CAP));
    assign acc.data_bit = data_bit;
    assign acc.count    = count_reg;
    assign acc.pending  = pending_reg;
    assign acc.clear    = finish;

    // current serial position
    assign cur_bit  = bits_sr_reg[0];
    assign is_arg   = !(ones_sr_reg[0] | zeros_sr_reg[0]);
    assign scan_end = (pos_reg == count_reg);

    // instruction done once its final field is placed
    assign finish = slot_free
                    && (((state_reg == S_EMIT_OP) && !has_arg_reg)
                        || (state_reg == S_EMIT_LAST));

    // a new output word is placed this cycle
    assign out_load = slot_free
                      && ((state_reg == S_EMIT_OP)
                          || (state_reg == S_EMIT_LAST)
                          || ((state_reg == S_SCAN_ARG) && !scan_end
                              && is_arg && open_reg && st_sr_reg[0]));

    ifs_matcher #(
        .TEMPLATES (TEMPLATES),
        .IDX_W     (IDX_W)
    ) u_matcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .acc       (acc),
        .hit       (hit),
        .hit_index (hit_index),
        .rd_index  (fmt_reg),
        .rd_entry  (rd_entry)
    );

    // sequencer, shift registers and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            has_arg_reg   <= 1'b0;
            open_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (acc.push)
                    begin
                        pending_reg <= pending_next;
                        count_reg   <= count_reg + ifs_pkg::CNT_W'(1);
                        if (hit)
                        begin
                            fmt_reg   <= hit_index;
                            state_reg <= S_LOAD_OP;
                        end
                    end
                end
                S_LOAD_OP, S_LOAD_ARG:
                begin
                    bits_sr_reg  <= pending_reg;
                    ones_sr_reg  <= rd_entry.ones;
                    zeros_sr_reg <= rd_entry.zeros;
                    op_sr_reg    <= rd_entry.opcode;
                    st_sr_reg    <= rd_entry.starts;
                    pos_reg      <= '0;
                    if (state_reg == S_LOAD_OP)
                    begin
                        op_val_reg  <= '0;
                        op_w_reg    <= '0;
                        has_arg_reg <= 1'b0;
                        state_reg   <= S_SCAN_OP;
                    end
                    else
                    begin
                        arg_val_reg <= '0;
                        arg_w_reg   <= '0;
                        open_reg    <= 1'b0;
                        state_reg   <= S_SCAN_ARG;
                    end
                end
                S_SCAN_OP:
                begin
                    if (scan_end)
                    begin
                        state_reg <= S_EMIT_OP;
                    end
                    else
                    begin
                        if (op_sr_reg[0])
                        begin
                            op_val_reg[op_w_reg[4:0]] <= cur_bit;
                            op_w_reg <= op_w_reg + ifs_pkg::CNT_W'(1);
                        end
                        has_arg_reg  <= has_arg_reg | is_arg;
                        bits_sr_reg  <= bits_sr_reg >> 1;
                        ones_sr_reg  <= ones_sr_reg >> 1;
                        zeros_sr_reg <= zeros_sr_reg >> 1;
                        op_sr_reg    <= op_sr_reg >> 1;
                        st_sr_reg    <= st_sr_reg >> 1;
                        pos_reg      <= pos_reg + ifs_pkg::CNT_W'(1);
                    end
                end
                S_EMIT_OP:
                begin
                    if (slot_free)
                    begin
                        out_kind_reg  <= ifs_pkg::KIND_OPCODE;
                        out_value_reg <= op_val_reg;
                        out_width_reg <= op_w_reg;
                        out_fmt_reg   <= 4'(fmt_reg);
                        out_last_reg  <= !has_arg_reg;
                        if (has_arg_reg)
                        begin
                            state_reg <= S_LOAD_ARG;
                        end
                        else
                        begin
                            pending_reg <= '0;
                            count_reg   <= '0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                S_SCAN_ARG:
                begin
                    if (scan_end)
                    begin
                        state_reg <= S_EMIT_LAST;
                    end
                    else if (!(is_arg && open_reg && st_sr_reg[0]) || slot_free)
                    begin
                        if (is_arg)
                        begin
                            if (open_reg && st_sr_reg[0])
                            begin
                                // start mark closes the open argument
                                out_kind_reg  <= ifs_pkg::KIND_ARG;
                                out_value_reg <= arg_val_reg;
                                out_width_reg <= arg_w_reg;
                                out_fmt_reg   <= 4'(fmt_reg);
                                out_last_reg  <= 1'b0;
                                arg_val_reg   <= ifs_pkg::WORD_W'(cur_bit);
                                arg_w_reg     <= ifs_pkg::CNT_W'(1);
                            end
                            else if (!open_reg)
                            begin
                                open_reg    <= 1'b1;
                                arg_val_reg <= ifs_pkg::WORD_W'(cur_bit);
                                arg_w_reg   <= ifs_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                arg_val_reg[arg_w_reg[4:0]] <= cur_bit;
                                arg_w_reg <= arg_w_reg + ifs_pkg::CNT_W'(1);
                            end
                        end
                        bits_sr_reg  <= bits_sr_reg >> 1;
                        ones_sr_reg  <= ones_sr_reg >> 1;
                        zeros_sr_reg <= zeros_sr_reg >> 1;
                        op_sr_reg    <= op_sr_reg >> 1;
                        st_sr_reg    <= st_sr_reg >> 1;
                        pos_reg      <= pos_reg + ifs_pkg::CNT_W'(1);
                    end
                end
                S_EMIT_LAST:
                begin
                    if (slot_free)
                    begin
                        out_kind_reg  <= ifs_pkg::KIND_ARG;
                        out_value_reg <= arg_val_reg;
                        out_width_reg <= arg_w_reg;
                        out_fmt_reg   <= 4'(fmt_reg);
                        out_last_reg  <= 1'b1;
                        pending_reg   <= '0;
                        count_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // output ports
    assign out_valid     = out_valid_reg;
    assign field_kind    = out_kind_reg;
    assign field_value   = out_value_reg;
    assign field_width   = out_width_reg;
    assign format_number = out_fmt_reg;
    assign last          = out_last_reg;

endmodule

// ===== tb/ifs_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// ifs_tb_pkg
// Codes and sizes shared by the splitter testbench top and its checker.
// ----------------------------------------------------------------------------
package ifs_tb_pkg;

    // input word modes
    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // template table depth and accumulator limit of the default build
    localparam int TABLE_SIZE = 16;
    localparam int ACC_LIMIT  = 32;

endpackage

// ===== tb/format_split_checker.sv =====
// ----------------------------------------------------------------------------
// format_split_checker
// Watches both channels of the instruction format splitter, tracks the
// template table and bit accumulator, and compares every output word with
// the next expected field.
// ----------------------------------------------------------------------------
module format_split_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic        data_bit,
    input  logic [3:0]  entry_index,
    input  logic [2:0]  word_select,
    input  logic [31:0] word_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        field_kind,
    input  logic [31:0] field_value,
    input  logic [5:0]  field_width,
    input  logic [3:0]  format_number,
    input  logic        last,
    output int          error_count,
    output int          fields_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [5:0]  width;
        logic [3:0]  fmt;
        logic        last;
    } split_field_t;

    // shadow of the block state
    logic [31:0]  acc_bits;
    int           acc_count;
    logic [5:0]   tpl_len    [ifs_tb_pkg::TABLE_SIZE];
    logic [31:0]  tpl_ones   [ifs_tb_pkg::TABLE_SIZE];
    logic [31:0]  tpl_zeros  [ifs_tb_pkg::TABLE_SIZE];
    logic [31:0]  tpl_op     [ifs_tb_pkg::TABLE_SIZE];
    logic [31:0]  tpl_starts [ifs_tb_pkg::TABLE_SIZE];

    split_field_t owed_fields[$];
    split_field_t arg_fields[$];
    int           mismatches;

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        int           t;
        int           i;
        int           hit;
        int           op_w;
        int           arg_w;
        logic [31:0]  lm;
        logic [31:0]  op_val;
        logic [31:0]  arg_val;
        logic         arg_open;
        logic         b;
        split_field_t nf;
        split_field_t got;
        split_field_t want;

        if (!rst_n)
        begin
            acc_bits  = '0;
            acc_count = 0;
            for (t = 0; t < ifs_tb_pkg::TABLE_SIZE; t++)
            begin
                tpl_len[t]    = '0;
                tpl_ones[t]   = '0;
                tpl_zeros[t]  = '0;
                tpl_op[t]     = '0;
                tpl_starts[t] = '0;
            end
            owed_fields.delete();
            mismatches  = 0;
            error_count <= 0;
            fields_owed <= 0;
        end
        else
        begin
            // accepted input word
            if (in_valid && !in_stall)
            begin
                if (mode == ifs_tb_pkg::MODE_WRITE)
                begin
                    if (entry_index < ifs_tb_pkg::TABLE_SIZE)
                    begin
                        case (word_select)
                            ifs_pkg::SEL_LENGTH: tpl_len[entry_index]    = word_value[5:0];
                            ifs_pkg::SEL_ONES:   tpl_ones[entry_index]   = word_value;
                            ifs_pkg::SEL_ZEROS:  tpl_zeros[entry_index]  = word_value;
                            ifs_pkg::SEL_OPCODE: tpl_op[entry_index]     = word_value;
                            ifs_pkg::SEL_STARTS: tpl_starts[entry_index] = word_value;
                            default: ;
                        endcase
                    end
                end
                else if (acc_count < ifs_tb_pkg::ACC_LIMIT)
                begin
                    acc_bits[acc_count] = data_bit;
                    acc_count++;
                    lm  = (acc_count >= 32) ? '1 : ((32'd1 << acc_count) - 32'd1);
                    hit = -1;
                    // lowest entry whose length and fixed bits agree wins
                    for (t = 0; t < ifs_tb_pkg::TABLE_SIZE && hit < 0; t++)
                    begin
                        if (tpl_len[t] != 0 && tpl_len[t] == acc_count
                            && ((~acc_bits & tpl_ones[t] & lm) == 0)
                            && ((acc_bits & tpl_zeros[t] & lm) == 0))
                            hit = t;
                    end
                    if (hit >= 0)
                    begin
                        op_val   = '0;
                        op_w     = 0;
                        arg_val  = '0;
                        arg_w    = 0;
                        arg_open = 1'b0;
                        arg_fields.delete();
                        // walk positions: opcode bits and argument bits may overlap
                        for (i = 0; i < tpl_len[hit]; i++)
                        begin
                            b = acc_bits[i];
                            if (tpl_op[hit][i])
                            begin
                                op_val[op_w] = b;
                                op_w++;
                            end
                            if (!tpl_ones[hit][i] && !tpl_zeros[hit][i])
                            begin
                                if (!arg_open || tpl_starts[hit][i])
                                begin
                                    if (arg_open)
                                    begin
                                        nf = {ifs_pkg::KIND_ARG, arg_val, 6'(arg_w),
                                              4'(hit), 1'b0};
                                        arg_fields = {arg_fields, nf};
                                    end
                                    arg_open = 1'b1;
                                    arg_val  = '0;
                                    arg_w    = 0;
                                end
                                arg_val[arg_w] = b;
                                arg_w++;
                            end
                        end
                        if (arg_open)
                        begin
                            nf = {ifs_pkg::KIND_ARG, arg_val, 6'(arg_w), 4'(hit), 1'b1};
                            arg_fields = {arg_fields, nf};
                        end
                        nf = {ifs_pkg::KIND_OPCODE, op_val, 6'(op_w), 4'(hit), !arg_open};
                        owed_fields = {owed_fields, nf};
                        owed_fields = {owed_fields, arg_fields};
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                end
            end

            // accepted output word
            if (out_valid && !out_stall)
            begin
                got = {field_kind, field_value, field_width, format_number, last};
                if (owed_fields.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: unexpected field: kind %0d value %h width %0d",
                                  " fmt %0d last %0d"},
                                 $realtime, got.kind, got.value, got.width, got.fmt,
                                 got.last);
                end
                else
                begin
                    want = owed_fields.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: field mismatch: expected kind %0d value %h width %0d",
                                      " fmt %0d last %0d, got kind %0d value %h width %0d",
                                      " fmt %0d last %0d"},
                                     $realtime, want.kind, want.value, want.width, want.fmt,
                                     want.last, got.kind, got.value, got.width, got.fmt,
                                     got.last);
                    end
                end
            end

            error_count <= mismatches;
            fields_owed <= owed_fields.size();
        end
    end

endmodule

// ===== tb/tb_instruction_format_splitter_core.sv =====
// ----------------------------------------------------------------------------
// tb_instruction_format_splitter_core
// Drives template writes and stream bits into the splitter with random
// gaps and output stalls; the checker beside the block predicts the fields.
// ----------------------------------------------------------------------------
module tb_instruction_format_splitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
    localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;
    localparam int         CATCH_ALL       = 15;
    localparam int         WORD_TARGET     = 380;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         DRAIN_CYCLES    = 100;
    localparam int         CYCLE_LIMIT     = 500000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        mode        = ifs_tb_pkg::MODE_DATA;
    logic        data_bit    = 1'b0;
    logic [3:0]  entry_index = '0;
    logic [2:0]  word_select = '0;
    logic [31:0] word_value  = '0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        field_kind;
    logic [31:0] field_value;
    logic [5:0]  field_width;
    logic [3:0]  format_number;
    logic        last;

    int          error_count;
    int          fields_owed;
    int unsigned cycle_count = 0;
    int          words_sent  = 0;
    bit          send_burst  = 1'b0;
    bit          recv_burst  = 1'b0;
    bit          hold_req    = 1'b0;

    // what the stimulus has written, used only to aim bits at a template
    logic [5:0]  shadow_len   [ifs_tb_pkg::TABLE_SIZE] = '{default: '0};
    logic [31:0] shadow_ones  [ifs_tb_pkg::TABLE_SIZE] = '{default: '0};
    logic [31:0] shadow_zeros [ifs_tb_pkg::TABLE_SIZE] = '{default: '0};

    instruction_format_splitter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .data_bit      (data_bit),
        .entry_index   (entry_index),
        .word_select   (word_select),
        .word_value    (word_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_kind    (field_kind),
        .field_value   (field_value),
        .field_width   (field_width),
        .format_number (format_number),
        .last          (last)
    );

    format_split_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .data_bit      (data_bit),
        .entry_index   (entry_index),
        .word_select   (word_select),
        .word_value    (word_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_kind    (field_kind),
        .field_value   (field_value),
        .field_width   (field_width),
        .format_number (format_number),
        .last          (last),
        .error_count   (error_count),
        .fields_owed   (fields_owed)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("instruction_format_splitter_core test failed");
            $finish;
        end
    end

    // one input word, held until accepted; valid stays high across back-to-back words
    task automatic put_word(input logic m, input logic b, input logic [3:0] idx,
                            input logic [2:0] sel, input logic [31:0] val);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        data_bit    <= b;
        entry_index <= idx;
        word_select <= sel;
        word_value  <= val;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic write_word(input int e, input logic [2:0] sel, input logic [31:0] val);
        case (sel)
            ifs_pkg::SEL_LENGTH: shadow_len[e]   = val[5:0];
            ifs_pkg::SEL_ONES:   shadow_ones[e]  = val;
            ifs_pkg::SEL_ZEROS:  shadow_zeros[e] = val;
            default: ;
        endcase
        put_word(ifs_tb_pkg::MODE_WRITE, 1'($urandom()), 4'(e), sel, val);
    endtask

    // writes that never create a template able to match
    task automatic noise_write();
        int e;
        e = $urandom_range(4, 14);
        case ($urandom_range(0, 2))
            0: put_word(ifs_tb_pkg::MODE_WRITE, 1'($urandom()), 4'($urandom()),
                        3'($urandom_range(SEL_SPARE_FIRST, SEL_SPARE_LAST)), $urandom());
            1: write_word(e, ifs_pkg::SEL_LENGTH, ($urandom() & ~32'h3F)
                          | ($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(33, 63))));
            default: write_word(e, 3'($urandom_range(int'(ifs_pkg::SEL_ONES),
                                                     int'(ifs_pkg::SEL_STARTS))),
                                $urandom());
        endcase
    endtask

    task automatic send_bits(input logic [31:0] bits, input int n, input bit noisy);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 11) == 0)
                noise_write();
            put_word(ifs_tb_pkg::MODE_DATA, bits[i], 4'($urandom()), 3'($urandom()),
                     $urandom());
        end
    endtask

    // entries 0..3 random at length len (or never matching), entry 15 catches the rest
    task automatic program_phase(input int len);
        int          e;
        int          kind;
        int          tl;
        int          p;
        logic [31:0] fixed;
        logic [31:0] pattern;
        logic [31:0] ones;
        logic [31:0] zeros;
        for (e = 0; e < 4; e++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                tl = len;
            else if (kind == 8)
                tl = $urandom_range(33, 63);
            else if (kind == 9 && len < 32)
                tl = $urandom_range(len + 1, 32);
            else
                tl = 0;
            case ($urandom_range(0, 2))
                0: fixed = $urandom() & $urandom();
                1: fixed = $urandom();
                default: fixed = $urandom() | $urandom();
            endcase
            pattern = $urandom();
            ones    = fixed & pattern;
            zeros   = fixed & ~pattern;
            // a position both one and zero kills the entry
            if ($urandom_range(0, 7) == 0)
            begin
                p        = $urandom_range(0, len - 1);
                ones[p]  = 1'b1;
                zeros[p] = 1'b1;
            end
            write_word(e, ifs_pkg::SEL_LENGTH, ($urandom() & ~32'h3F) | 32'(tl));
            write_word(e, ifs_pkg::SEL_ONES, ones);
            write_word(e, ifs_pkg::SEL_ZEROS, zeros);
            write_word(e, ifs_pkg::SEL_OPCODE, $urandom());
            write_word(e, ifs_pkg::SEL_STARTS,
                       $urandom_range(0, 1) ? $urandom() : $urandom() & $urandom());
        end
        write_word(CATCH_ALL, ifs_pkg::SEL_LENGTH, ($urandom() & ~32'h3F) | 32'(len));
        write_word(CATCH_ALL, ifs_pkg::SEL_OPCODE, $urandom());
        write_word(CATCH_ALL, ifs_pkg::SEL_STARTS, $urandom());
    endtask

    // one instruction of len bits, mostly shaped to fit a chosen template
    task automatic send_instruction(input int len);
        int          cand[$];
        int          e;
        int          target;
        logic [31:0] bits;
        for (e = 0; e < 4; e++)
            if (shadow_len[e] == len)
                cand = {cand, e};
        cand = {cand, CATCH_ALL};
        target = cand[$urandom_range(0, cand.size() - 1)];
        bits   = $urandom();
        if ($urandom_range(0, 4) != 0)
            bits = (bits & ~(shadow_ones[target] | shadow_zeros[target]))
                   | shadow_ones[target];
        send_bits(bits, len, 1'b1);
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int hold;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                recv_burst = !recv_burst;
            if (hold_req && !hold_done)
            begin
                hold      = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
                hold = recv_burst ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial
    begin : stimulus
        int phase;
        int len;
        int n;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: conflicting entry, overlapping opcode and argument,
        // fully fixed entry with empty opcode, catch-all, ignored select
        write_word(0, ifs_pkg::SEL_LENGTH, 32'd4);
        write_word(0, ifs_pkg::SEL_ONES, 32'h1);
        write_word(0, ifs_pkg::SEL_ZEROS, 32'h1);
        write_word(1, ifs_pkg::SEL_LENGTH, 32'd4);
        write_word(1, ifs_pkg::SEL_ONES, 32'h3);
        write_word(1, ifs_pkg::SEL_ZEROS, 32'h4);
        write_word(1, ifs_pkg::SEL_OPCODE, 32'hF);
        write_word(1, ifs_pkg::SEL_STARTS, 32'h0);
        write_word(2, ifs_pkg::SEL_LENGTH, 32'd4);
        write_word(2, ifs_pkg::SEL_ONES, 32'hC);
        write_word(2, ifs_pkg::SEL_ZEROS, 32'h3);
        write_word(CATCH_ALL, ifs_pkg::SEL_LENGTH, 32'd4);
        put_word(ifs_tb_pkg::MODE_WRITE, 1'b1, 4'hF, SEL_SPARE_LAST, 32'hFFFF_FFFF);
        send_bits(32'hB, 4, 1'b0);
        send_bits(32'hC, 4, 1'b0);
        send_bits(32'h7, 4, 1'b0);

        // random phases, each with a single instruction length
        phase = 0;
        while (words_sent < WORD_TARGET)
        begin
            if (phase == 0)
                len = 1;
            else if (phase == 1)
                len = 32;
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(13, 32);
            else
                len = $urandom_range(1, 12);
            program_phase(len);
            if (phase == 1)
                hold_req = 1'b1;
            n = (len > 16) ? $urandom_range(2, 4) : $urandom_range(6, 14);
            repeat (n) send_instruction(len);
            phase++;
        end

        // saturation: nothing can match, accumulator fills and then drops bits
        write_word(0, ifs_pkg::SEL_LENGTH, $urandom() & ~32'h3F);
        write_word(1, ifs_pkg::SEL_LENGTH, $urandom() & ~32'h3F);
        write_word(2, ifs_pkg::SEL_LENGTH, ($urandom() & ~32'h3F) | 32'd33);
        write_word(3, ifs_pkg::SEL_LENGTH, 32'hFFFF_FFFF);
        write_word(CATCH_ALL, ifs_pkg::SEL_LENGTH, $urandom() & ~32'h3F);
        send_bits($urandom(), 32, 1'b1);
        send_bits($urandom(), 4, 1'b0);
        write_word(1, ifs_pkg::SEL_LENGTH, ($urandom() & ~32'h3F) | 32'd32);
        write_word(1, ifs_pkg::SEL_ONES, 32'h0);
        write_word(1, ifs_pkg::SEL_ZEROS, 32'h0);
        send_bits($urandom(), 4, 1'b0);
        in_valid <= 1'b0;

        do @(posedge clk); while (fields_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && fields_owed == 0)
            $display("instruction_format_splitter_core test passed");
        else
            $display("instruction_format_splitter_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ifs_pkg.sv
design/ifs_matcher.sv
design/instruction_format_splitter_core.sv
tb/ifs_tb_pkg.sv
tb/format_split_checker.sv
tb/tb_instruction_format_splitter_core.sv
